/* sv/evt_pkg.sv */
`default_nettype none

package evt_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_X = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OFFSET_Y = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MONO    = 3'd6;

   localparam logic OP_MEASURE   = 1'b0;
   localparam logic OP_TRANSFORM = 1'b1;

   localparam logic [15:0] ANGLE_X_RESET = 16'd8192;
   localparam logic [15:0] ANGLE_Y_RESET = 16'd5461;
   localparam logic [15:0] ANGLE_Z_RESET = 16'd60075;
   localparam logic [9:0]  SCALE_RESET   = 10'd60;
   localparam logic signed [12:0] OFFSET_X_RESET = 13'sd960;
   localparam logic signed [12:0] OFFSET_Y_RESET = 13'sd540;

   localparam logic [31:0] MONO_COLOR = 32'hAAFF_FFFF;
   localparam int SCREEN_W = 1920;
   localparam int SCREEN_H = 1080;
   localparam logic signed [12:0] CENTRE_X = 13'sd960;
   localparam logic signed [12:0] CENTRE_Y = 13'sd540;

   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [14:0] QUARTER_TURN = 15'd16384;

   localparam logic [9:0] SCALE_DIV3_MUL = 10'd683;
   localparam int SCALE_DIV3_SH = 11;
   localparam logic [9:0] SCALE_MIN = 10'd3;

   localparam int DIV_NUM_BITS = 32;
   localparam int DIV_DEN_BITS = 8;
   localparam logic [2:0] SERIES_LAST = 3'd5;
   localparam logic [3:0] ENTRY_LAST  = 4'd8;
   localparam logic [1:0] AXIS_LAST   = 2'd2;
   localparam logic [1:0] ROW_LAST    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SIN_X,
      ST_SIN_X2,
      ST_SIN_P,
      ST_DIV_ST,
      ST_DIV,
      ST_SIN_S,
      ST_MAT_AB,
      ST_MAT_ABC,
      ST_MAT_STORE,
      ST_ROW,
      ST_FIT,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      OPND_ZERO,
      OPND_ONE,
      OPND_SX,
      OPND_CX,
      OPND_SY,
      OPND_CY,
      OPND_SZ,
      OPND_CZ
   } opnd_type;

   typedef struct packed {
      opnd_type a;
      opnd_type b;
      opnd_type c;
      logic     neg;
   } mat_term_type;

   typedef struct packed {
      logic       capture;
      logic       sin_x;
      logic       sin_x2;
      logic       sin_p;
      logic       div_start;
      logic       sin_t;
      logic       sin_s;
      logic       mat_ab;
      logic       mat_acc;
      logic       mat_store;
      logic       row;
      logic       fit_shrink;
      logic       emit;
      logic [1:0] axis;
      logic       half;
      logic [2:0] k;
      logic [3:0] ent;
      logic       term;
      logic [1:0] row_idx;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic fit_done;
      logic is_transform;
      logic rsp_free;
   } dp_status_type;

   function automatic logic [DIV_DEN_BITS-1:0] series_div(input logic [2:0] k);
      logic [DIV_DEN_BITS-1:0] d;
      case (k)
         3'd0: d = 8'd156;
         3'd1: d = 8'd110;
         3'd2: d = 8'd72;
         3'd3: d = 8'd42;
         3'd4: d = 8'd20;
         default: d = 8'd6;
      endcase
      return d;
   endfunction

   // Each matrix entry is one signed triple product or the sum of two.
   function automatic mat_term_type mat_term(input logic [3:0] ent, input logic term);
      mat_term_type t;
      t = '{a: OPND_ZERO, b: OPND_ZERO, c: OPND_ZERO, neg: 1'b0};
      case ({ent, term})
         {4'd0, 1'b0}: t = '{a: OPND_CZ, b: OPND_CY, c: OPND_ONE, neg: 1'b0};
         {4'd1, 1'b0}: t = '{a: OPND_CZ, b: OPND_SY, c: OPND_SX, neg: 1'b0};
         {4'd1, 1'b1}: t = '{a: OPND_SZ, b: OPND_CX, c: OPND_ONE, neg: 1'b1};
         {4'd2, 1'b0}: t = '{a: OPND_CZ, b: OPND_SY, c: OPND_CX, neg: 1'b0};
         {4'd2, 1'b1}: t = '{a: OPND_SZ, b: OPND_SX, c: OPND_ONE, neg: 1'b0};
         {4'd3, 1'b0}: t = '{a: OPND_SZ, b: OPND_CY, c: OPND_ONE, neg: 1'b0};
         {4'd4, 1'b0}: t = '{a: OPND_SZ, b: OPND_SY, c: OPND_SX, neg: 1'b0};
         {4'd4, 1'b1}: t = '{a: OPND_CZ, b: OPND_CX, c: OPND_ONE, neg: 1'b0};
         {4'd5, 1'b0}: t = '{a: OPND_SZ, b: OPND_SY, c: OPND_CX, neg: 1'b0};
         {4'd5, 1'b1}: t = '{a: OPND_CZ, b: OPND_SX, c: OPND_ONE, neg: 1'b1};
         {4'd6, 1'b0}: t = '{a: OPND_SY, b: OPND_ONE, c: OPND_ONE, neg: 1'b1};
         {4'd7, 1'b0}: t = '{a: OPND_CY, b: OPND_SX, c: OPND_ONE, neg: 1'b0};
         {4'd8, 1'b0}: t = '{a: OPND_CY, b: OPND_CX, c: OPND_ONE, neg: 1'b0};
         default: t = '{a: OPND_ZERO, b: OPND_ZERO, c: OPND_ZERO, neg: 1'b0};
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

/* sv/evt_div.sv */
`default_nettype none

module evt_div import evt_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DIV_NUM_BITS-1:0] dividend,
   input  wire logic [DIV_DEN_BITS-1:0] divisor,
   output logic                         done,
   output logic [DIV_NUM_BITS-1:0]      quotient
);

   // Every series divisor is an odd factor times a power of two. The power of two is
   // shifted out first, and the odd factor is a multiply by its rounded-up reciprocal,
   // which is exact for any dividend below 2**31.
   logic                          done_ff;
   logic [62:0]                   prod_ff;
   logic [5:0]                    sh_ff;
   logic [1:0]                    pre_sh;
   logic [31:0]                   recip;
   logic [5:0]                    post_sh;
   logic [30:0]                   num;

   always_comb begin
      case (divisor)
         8'd156: begin
            pre_sh  = 2'd2;
            recip   = 32'd3524075731;
            post_sh = 6'd37;
         end
         8'd110: begin
            pre_sh  = 2'd1;
            recip   = 32'd2498890064;
            post_sh = 6'd37;
         end
         8'd72: begin
            pre_sh  = 2'd3;
            recip   = 32'd3817748708;
            post_sh = 6'd35;
         end
         8'd42: begin
            pre_sh  = 2'd1;
            recip   = 32'd3272356036;
            post_sh = 6'd36;
         end
         8'd20: begin
            pre_sh  = 2'd2;
            recip   = 32'd3435973837;
            post_sh = 6'd34;
         end
         default: begin
            pre_sh  = 2'd1;
            recip   = 32'd2863311531;
            post_sh = 6'd33;
         end
      endcase
   end

   assign num = 31'(dividend >> pre_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff <= 63'(num) * 63'(recip);
         sh_ff   <= post_sh;
      end
   end

   assign done     = done_ff;
   assign quotient = DIV_NUM_BITS'(prod_ff >> sh_ff);

endmodule

`default_nettype wire

/* sv/evt_ctrl.sv */
`default_nettype none

module evt_ctrl import evt_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire dp_status_type             status,
   output ctrl_cmd_type                   cmd
);

   ctrl_state_type state_ff, state_in;
   logic       pend_ff;
   logic [1:0] axis_ff, axis_in;
   logic       half_ff, half_in;
   logic [2:0] k_ff, k_in;
   logic [3:0] ent_ff, ent_in;
   logic       term_ff, term_in;
   logic [1:0] row_ff, row_in;
   logic       ready;
   logic       angle_write;

   assign angle_write = csr_we && (csr_index == CSR_ANGLE_X || csr_index == CSR_ANGLE_Y
                                   || csr_index == CSR_ANGLE_Z);
   assign ready = (state_ff == ST_IDLE) && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b1;
         axis_ff  <= '0;
         half_ff  <= 1'b0;
         k_ff     <= '0;
         ent_ff   <= '0;
         term_ff  <= 1'b0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (angle_write) begin
            pend_ff <= 1'b1;
         end else if (state_ff == ST_IDLE) begin
            pend_ff <= 1'b0;
         end
         axis_ff <= axis_in;
         half_ff <= half_in;
         k_ff    <= k_in;
         ent_ff  <= ent_in;
         term_ff <= term_in;
         row_ff  <= row_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pend_ff) begin
               state_in = ST_SIN_X;
            end else if (req_valid) begin
               state_in = ST_ROW;
            end
         end
         ST_SIN_X:  state_in = ST_SIN_X2;
         ST_SIN_X2: state_in = ST_SIN_P;
         ST_SIN_P:  state_in = ST_DIV_ST;
         ST_DIV_ST: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_done) begin
               state_in = (k_ff == SERIES_LAST) ? ST_SIN_S : ST_SIN_P;
            end
         end
         ST_SIN_S: begin
            state_in = (half_ff && axis_ff == AXIS_LAST) ? ST_MAT_AB : ST_SIN_X;
         end
         ST_MAT_AB:  state_in = ST_MAT_ABC;
         ST_MAT_ABC: state_in = term_ff ? ST_MAT_STORE : ST_MAT_AB;
         ST_MAT_STORE: begin
            state_in = (ent_ff == ENTRY_LAST) ? ST_IDLE : ST_MAT_AB;
         end
         ST_ROW: begin
            if (row_ff == ROW_LAST) begin
               state_in = status.is_transform ? ST_EMIT : ST_FIT;
            end
         end
         ST_FIT: begin
            if (status.fit_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      axis_in = axis_ff;
      half_in = half_ff;
      k_in    = k_ff;
      ent_in  = ent_ff;
      term_in = term_ff;
      row_in  = row_ff;
      case (state_ff)
         ST_IDLE: begin
            axis_in = '0;
            half_in = 1'b0;
            row_in  = '0;
         end
         ST_SIN_X2: k_in = '0;
         ST_DIV: begin
            if (status.div_done && k_ff != SERIES_LAST) begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_SIN_S: begin
            half_in = !half_ff;
            if (half_ff) begin
               axis_in = axis_ff + 1'b1;
            end
            ent_in  = '0;
            term_in = 1'b0;
         end
         ST_MAT_ABC: term_in = 1'b1;
         ST_MAT_STORE: begin
            term_in = 1'b0;
            ent_in  = ent_ff + 1'b1;
         end
         ST_ROW: row_in = row_ff + 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.axis       = axis_ff;
      cmd.half       = half_ff;
      cmd.k          = k_ff;
      cmd.ent        = ent_ff;
      cmd.term       = term_ff;
      cmd.row_idx    = row_ff;
      cmd.capture    = ready && req_valid;
      cmd.sin_x      = state_ff == ST_SIN_X;
      cmd.sin_x2     = state_ff == ST_SIN_X2;
      cmd.sin_p      = state_ff == ST_SIN_P;
      cmd.div_start  = state_ff == ST_DIV_ST;
      cmd.sin_t      = state_ff == ST_DIV && status.div_done;
      cmd.sin_s      = state_ff == ST_SIN_S;
      cmd.mat_ab     = state_ff == ST_MAT_AB;
      cmd.mat_acc    = state_ff == ST_MAT_ABC;
      cmd.mat_store  = state_ff == ST_MAT_STORE;
      cmd.row        = state_ff == ST_ROW;
      cmd.fit_shrink = state_ff == ST_FIT && !status.fit_done;
      cmd.emit       = state_ff == ST_EMIT && status.rsp_free;
      req_ready      = ready;
   end

endmodule

`default_nettype wire

/* sv/evt_dp.sv */
`default_nettype none

module evt_dp import evt_pkg::*; #(
   parameter int COORD_BITS     = 12,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ctrl_cmd_type                  cmd,
   output dp_status_type                      status,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          req_opcode,
   input  wire logic                          req_pass_start,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_y,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_z,
   input  wire logic [31:0]                   req_point_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [23:0]                 rsp_screen_x,
   output logic signed [23:0]                 rsp_screen_y,
   output logic signed [20:0]                 rsp_depth,
   output logic [31:0]                        rsp_out_color,
   output logic [9:0]                         rsp_used_scale
);

   localparam int F   = COEF_FRAC_BITS;
   localparam int CW  = F + 2;
   localparam int QW  = F + 1;
   localparam int RW  = CW + COORD_BITS + 2;
   localparam int PW  = RW + 12;
   localparam int AW  = 3 * CW + 1;
   localparam int RND = 30 - F;

   logic [15:0]        ang_ff [3];
   logic [9:0]         scale_init_ff;
   logic signed [12:0] offx_ff;
   logic signed [12:0] offy_ff;
   logic               mono_ff;

   logic                         op_ff;
   logic signed [COORD_BITS-1:0] cx_ff, cy_ff, cz_ff;
   logic [31:0]                  color_ff;
   logic [9:0]                   scale_ff;
   logic                         halted_ff;

   logic [30:0] x_ff;
   logic [31:0] x2_ff;
   logic [30:0] t_ff;
   logic [31:0] p_ff;
   logic [QW-1:0] qs_ff [3];
   logic [QW-1:0] qc_ff [3];

   logic signed [2*CW-1:0] prod1_ff;
   logic signed [AW-1:0]   acc_ff;
   logic signed [CW-1:0]   coef_ff [9];
   logic signed [RW-1:0]   rr_ff [3];

   logic         rsp_valid_ff;
   logic signed [23:0] sx_ff, sy_ff;
   logic signed [20:0] dep_ff;
   logic [31:0]  ocol_ff;
   logic [9:0]   used_ff;

   logic [15:0] ang_sel;
   logic [14:0] r_eff;
   logic [46:0] x_prod;
   logic [61:0] xx_prod;
   logic [62:0] pt_prod;
   logic [61:0] st_prod;
   logic [31:0] s_rnd;
   logic [31:0] quot;
   logic        div_done;

   logic signed [CW-1:0] sv [3];
   logic signed [CW-1:0] cv [3];
   logic signed [CW-1:0] opnd_val [8];
   mat_term_type         mt;
   logic signed [AW-1:0] prod2;
   logic signed [AW-1:0] acc_base;
   logic signed [AW-1:0] cf_full;
   logic signed [RW-1:0] dot;

   logic signed [12:0] base_x, base_y;
   logic signed [PW-1:0] wx, wy, px, py;
   logic                 on_screen;
   logic [19:0]          third_prod;
   logic [9:0]           scale_next;
   logic signed [RW-1:0] dep_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff[0]     <= ANGLE_X_RESET;
         ang_ff[1]     <= ANGLE_Y_RESET;
         ang_ff[2]     <= ANGLE_Z_RESET;
         scale_init_ff <= SCALE_RESET;
         offx_ff       <= OFFSET_X_RESET;
         offy_ff       <= OFFSET_Y_RESET;
         mono_ff       <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ANGLE_X:  ang_ff[0]     <= csr_wdata;
            CSR_ANGLE_Y:  ang_ff[1]     <= csr_wdata;
            CSR_ANGLE_Z:  ang_ff[2]     <= csr_wdata;
            CSR_SCALE:    scale_init_ff <= csr_wdata[9:0];
            CSR_OFFSET_X: offx_ff       <= $signed(csr_wdata[12:0]);
            CSR_OFFSET_Y: offy_ff       <= $signed(csr_wdata[12:0]);
            CSR_MONO:     mono_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Quarter-wave sine by a truncating Taylor series in Q30.
   assign ang_sel = ang_ff[cmd.axis];
   assign r_eff   = cmd.half ? QUARTER_TURN - {1'b0, ang_sel[13:0]} : {1'b0, ang_sel[13:0]};
   assign x_prod  = 47'(r_eff) * 47'(PI_Q30);
   assign xx_prod = 62'(x_ff) * 62'(x_ff);
   assign pt_prod = 63'(x2_ff) * 63'(t_ff);
   assign st_prod = 62'(x_ff) * 62'(t_ff);
   assign s_rnd   = st_prod[61:30] + (32'd1 << (RND - 1));

   evt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (p_ff),
      .divisor  (series_div(cmd.k)),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.sin_x) begin
         x_ff <= x_prod[45:15];
      end
      if (cmd.sin_x2) begin
         x2_ff <= xx_prod[61:30];
         t_ff  <= Q30_ONE;
      end else if (cmd.sin_t) begin
         t_ff <= Q30_ONE - quot[30:0];
      end
      if (cmd.sin_p) begin
         p_ff <= pt_prod[61:30];
      end
      if (cmd.sin_s) begin
         if (cmd.half) begin
            qc_ff[cmd.axis] <= QW'(s_rnd >> RND);
         end else begin
            qs_ff[cmd.axis] <= QW'(s_rnd >> RND);
         end
      end
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         case (ang_ff[a][15:14])
            2'd0: begin
               sv[a] = $signed({1'b0, qs_ff[a]});
               cv[a] = $signed({1'b0, qc_ff[a]});
            end
            2'd1: begin
               sv[a] = $signed({1'b0, qc_ff[a]});
               cv[a] = -$signed({1'b0, qs_ff[a]});
            end
            2'd2: begin
               sv[a] = -$signed({1'b0, qs_ff[a]});
               cv[a] = -$signed({1'b0, qc_ff[a]});
            end
            default: begin
               sv[a] = -$signed({1'b0, qc_ff[a]});
               cv[a] = $signed({1'b0, qs_ff[a]});
            end
         endcase
      end
   end

   always_comb begin
      opnd_val[OPND_ZERO] = '0;
      opnd_val[OPND_ONE]  = $signed(CW'(1) << F);
      opnd_val[OPND_SX]   = sv[0];
      opnd_val[OPND_CX]   = cv[0];
      opnd_val[OPND_SY]   = sv[1];
      opnd_val[OPND_CY]   = cv[1];
      opnd_val[OPND_SZ]   = sv[2];
      opnd_val[OPND_CZ]   = cv[2];
   end

   assign mt       = mat_term(cmd.ent, cmd.term);
   assign prod2    = AW'(prod1_ff) * AW'(opnd_val[mt.c]);
   assign acc_base = cmd.term ? acc_ff : '0;
   assign cf_full  = (acc_ff + (AW'(1) <<< (2 * F - 1))) >>> (2 * F);
   assign dot      = RW'(coef_ff[0]) * RW'(cx_ff) + RW'(coef_ff[1]) * RW'(cy_ff)
                   + RW'(coef_ff[2]) * RW'(cz_ff);

   always_ff @(posedge clock) begin
      if (cmd.mat_ab) begin
         prod1_ff <= (2*CW)'(opnd_val[mt.a]) * (2*CW)'(opnd_val[mt.b]);
      end
      if (cmd.mat_acc) begin
         acc_ff <= mt.neg ? acc_base - prod2 : acc_base + prod2;
      end
      // The coefficient line shifts in during the build and rotates by one row per
      // row product, so three rows bring it back to its starting order.
      if (cmd.mat_store) begin
         for (int i = 0; i < 8; i++) begin
            coef_ff[i] <= coef_ff[i+1];
         end
         coef_ff[8] <= cf_full[CW-1:0];
      end else if (cmd.row) begin
         for (int i = 0; i < 9; i++) begin
            coef_ff[i] <= coef_ff[(i + 3) % 9];
         end
      end
      if (cmd.row) begin
         rr_ff[cmd.row_idx] <= dot;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         cx_ff    <= req_coord_x;
         cy_ff    <= req_coord_y;
         cz_ff    <= req_coord_z;
         color_ff <= req_point_color;
      end
   end

   assign base_x = (op_ff == OP_TRANSFORM) ? offx_ff : CENTRE_X;
   assign base_y = (op_ff == OP_TRANSFORM) ? offy_ff : CENTRE_Y;
   assign wx = PW'(rr_ff[0]) * $signed(PW'({1'b0, scale_ff})) + (PW'(base_x) <<< F);
   assign wy = PW'(rr_ff[1]) * $signed(PW'({1'b0, scale_ff})) + (PW'(base_y) <<< F);
   assign px = (wx + (wx[PW-1] ? $signed((PW'(1) << F) - PW'(1)) : $signed(PW'(0)))) >>> F;
   assign py = (wy + (wy[PW-1] ? $signed((PW'(1) << F) - PW'(1)) : $signed(PW'(0)))) >>> F;
   assign on_screen = !px[PW-1] && (px <= $signed(PW'(SCREEN_W)))
                   && !py[PW-1] && (py <= $signed(PW'(SCREEN_H)));
   assign third_prod = 20'(scale_ff) * 20'(SCALE_DIV3_MUL);
   assign scale_next = {third_prod[SCALE_DIV3_SH+8:SCALE_DIV3_SH], 1'b0};
   assign dep_full   = (rr_ff[2] + (RW'(1) <<< (F - 9))) >>> (F - 8);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_RESET;
         halted_ff <= 1'b0;
      end else if (cmd.capture && req_opcode == OP_MEASURE && req_pass_start) begin
         scale_ff  <= scale_init_ff;
         halted_ff <= 1'b0;
      end else if (cmd.fit_shrink) begin
         scale_ff  <= scale_next;
         halted_ff <= scale_next < SCALE_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         sx_ff   <= px[23:0];
         sy_ff   <= py[23:0];
         dep_ff  <= dep_full[20:0];
         ocol_ff <= mono_ff ? MONO_COLOR : color_ff;
         used_ff <= scale_ff;
      end
   end

   assign status.div_done     = div_done;
   assign status.fit_done     = halted_ff || on_screen;
   assign status.is_transform = op_ff == OP_TRANSFORM;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_screen_x   = sx_ff;
   assign rsp_screen_y   = sy_ff;
   assign rsp_depth      = dep_ff;
   assign rsp_out_color  = ocol_ff;
   assign rsp_used_scale = used_ff;

   a_scale_shrinks: assert property (@(posedge clock) disable iff (reset)
      !cmd.capture |=> scale_ff <= $past(scale_ff))
      else $error("fitted scale grew without a new pass");

   a_halt_small: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> scale_ff < SCALE_MIN)
      else $error("fit halted with a scale that is not small");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a word still waiting");

   a_shrink_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.fit_shrink |-> (!halted_ff && !on_screen))
      else $error("scale shrunk for a point already on screen");

endmodule

`default_nettype wire

/* sv/euler_vertex_transform_fit.sv */
// Rotates map points by Rz*Ry*Rx and projects them to the screen. An accepted
// item steps through the three row products of the rotation matrix and then
// into the fit test (measure item) or the output load (transform item); a
// measure item stays in the fit test for each scale reduction of the fit loop,
// and the output load waits while the output register holds an untaken word.
// Only one item is in the block at a time. After reset and after every write of an
// angle register the block rebuilds its nine coefficients and accepts no item
// until the rebuild is done; the rebuild computes six sines, each of six series
// steps (each step dividing by a constant through a reciprocal multiply), and
// then the nine matrix entries. A finished result waits in an output register,
// so the next item is accepted while it is still held.
`default_nettype none

module euler_vertex_transform_fit import evt_pkg::*; #(
   parameter int COORD_BITS     = 12,
   parameter int COEF_FRAC_BITS = 14
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_opcode,
   input  wire logic                          req_pass_start,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_x,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_y,
   input  wire logic signed [COORD_BITS-1:0]  req_coord_z,
   input  wire logic [31:0]                   req_point_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [23:0]                 rsp_screen_x,
   output logic signed [23:0]                 rsp_screen_y,
   output logic signed [20:0]                 rsp_depth,
   output logic [31:0]                        rsp_out_color,
   output logic [9:0]                         rsp_used_scale
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   evt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .status    (status),
      .cmd       (cmd)
   );

   evt_dp #(
      .COORD_BITS     (COORD_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_opcode),
      .req_pass_start  (req_pass_start),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_point_color (req_point_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_depth       (rsp_depth),
      .rsp_out_color   (rsp_out_color),
      .rsp_used_scale  (rsp_used_scale)
   );

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import evt_pkg::*;

   localparam int CF = 14;
   localparam int WATCHDOG_LIMIT = 30000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;
   localparam longint unsigned PI_FIX = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;

   typedef struct {
      logic signed [23:0] screen_x;
      logic signed [23:0] screen_y;
      logic signed [20:0] depth;
      logic [31:0]        color;
      logic [9:0]         scale;
   } vertex_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_MEASURE;
   logic req_pass_start = 1'b0;
   logic signed [11:0] req_coord_x = '0;
   logic signed [11:0] req_coord_y = '0;
   logic signed [11:0] req_coord_z = '0;
   logic [31:0] req_point_color = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [23:0] rsp_screen_x;
   logic signed [23:0] rsp_screen_y;
   logic signed [20:0] rsp_depth;
   logic [31:0] rsp_out_color;
   logic [9:0] rsp_used_scale;

   logic [15:0] ang_x, ang_y, ang_z;
   logic [9:0] init_scale, fit_scale;
   logic signed [12:0] off_x, off_y;
   logic mono;
   logic fit_halted;
   longint coef [9];

   vertex_word_t expected_words[$];
   int unsigned points_sent = 0;
   int unsigned words_checked = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned settings_used = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   euler_vertex_transform_fit u_top (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_pass_start(req_pass_start), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_point_color(req_point_color),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_screen_x(rsp_screen_x),
      .rsp_screen_y(rsp_screen_y), .rsp_depth(rsp_depth),
      .rsp_out_color(rsp_out_color), .rsp_used_scale(rsp_used_scale)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic longint round_half_up(longint v, int s);
      longint w;
      w = v + (longint'(1) << (s - 1));
      if (w >= 0) return w >>> s;
      return -((-w + (longint'(1) << s) - 1) >>> s);
   endfunction

   function automatic longint quarter_sine(int unsigned r);
      longint unsigned x, x2, t, s;
      x = (longint'(r) * PI_FIX) >> 15;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (int k = 12; k >= 2; k -= 2)
         t = ONE_Q30 - ((x2 * t) >> 30) / longint'(k * (k + 1));
      s = (x * t) >> 30;
      s = (s + (64'd1 << (29 - CF))) >> (30 - CF);
      return longint'(s);
   endfunction

   task automatic sine_cosine(input logic [15:0] a, output longint sv, output longint cv);
      longint s, c;
      s = quarter_sine(a[13:0]);
      c = quarter_sine(16384 - a[13:0]);
      case (a[15:14])
         2'd0: begin sv = s; cv = c; end
         2'd1: begin sv = c; cv = -s; end
         2'd2: begin sv = -s; cv = -c; end
         default: begin sv = -c; cv = s; end
      endcase
   endtask

   task automatic rebuild_rotation();
      longint sx, cx, sy, cy, sz, cz, one;
      longint m [9];
      one = longint'(1) << CF;
      sine_cosine(ang_x, sx, cx);
      sine_cosine(ang_y, sy, cy);
      sine_cosine(ang_z, sz, cz);
      m[0] = cz * cy * one;
      m[1] = cz * sy * sx - sz * cx * one;
      m[2] = cz * sy * cx + sz * sx * one;
      m[3] = sz * cy * one;
      m[4] = sz * sy * sx + cz * cx * one;
      m[5] = sz * sy * cx - cz * sx * one;
      m[6] = -sy * one * one;
      m[7] = cy * sx * one;
      m[8] = cy * cx * one;
      for (int i = 0; i < 9; i++) coef[i] = round_half_up(m[i], 2 * CF);
   endtask

   function automatic longint project(longint v, longint scale, longint base);
      return (v * scale + base * (longint'(1) << CF)) / (longint'(1) << CF);
   endfunction

   task automatic apply_register(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] value);
      case (idx)
         CSR_ANGLE_X: begin ang_x = value; rebuild_rotation(); end
         CSR_ANGLE_Y: begin ang_y = value; rebuild_rotation(); end
         CSR_ANGLE_Z: begin ang_z = value; rebuild_rotation(); end
         CSR_SCALE: init_scale = value[9:0];
         CSR_OFFSET_X: off_x = value[12:0];
         CSR_OFFSET_Y: off_y = value[12:0];
         CSR_MONO: mono = value[0];
         default: ;
      endcase
   endtask

   task automatic predict_vertex();
      longint x, y, z, rx, ry, rz, px, py;
      vertex_word_t w;
      x = req_coord_x;
      y = req_coord_y;
      z = req_coord_z;
      rx = coef[0] * x + coef[1] * y + coef[2] * z;
      ry = coef[3] * x + coef[4] * y + coef[5] * z;
      rz = coef[6] * x + coef[7] * y + coef[8] * z;
      if (req_opcode == OP_MEASURE) begin
         if (req_pass_start) begin
            fit_scale = init_scale;
            fit_halted = 1'b0;
         end
         while (!fit_halted) begin
            px = project(rx, fit_scale, SCREEN_W / 2);
            py = project(ry, fit_scale, SCREEN_H / 2);
            if (px >= 0 && px <= SCREEN_W && py >= 0 && py <= SCREEN_H) break;
            fit_scale = fit_scale / 3 * 2;
            if (fit_scale < SCALE_MIN) fit_halted = 1'b1;
         end
      end else begin
         w.screen_x = project(rx, fit_scale, off_x);
         w.screen_y = project(ry, fit_scale, off_y);
         w.depth = round_half_up(rz, CF - 8);
         w.color = mono ? MONO_COLOR : req_point_color;
         w.scale = fit_scale;
         expected_words.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      vertex_word_t w;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
         if (req_valid && req_ready) begin
            points_sent++;
            predict_vertex();
         end
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result word at %0t", $realtime);
            end else begin
               w = expected_words.pop_front();
               if (rsp_screen_x !== w.screen_x || rsp_screen_y !== w.screen_y ||
                   rsp_depth !== w.depth || rsp_out_color !== w.color ||
                   rsp_used_scale !== w.scale) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch at %0t: exp x=%0d y=%0d d=%0d c=%h s=%0d, got x=%0d y=%0d d=%0d c=%h s=%0d",
                        $realtime, w.screen_x, w.screen_y, w.depth, w.color, w.scale,
                        rsp_screen_x, rsp_screen_y, rsp_depth, rsp_out_color, rsp_used_scale);
               end
            end
         end
      end
   end

   task automatic send_point(logic op, logic ps, logic signed [11:0] x, logic signed [11:0] y,
                             logic signed [11:0] z, logic [31:0] color);
      int unsigned seen;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_opcode = op;
      req_pass_start = ps;
      req_coord_x = x;
      req_coord_y = y;
      req_coord_z = z;
      req_point_color = color;
      req_valid = 1'b1;
      seen = points_sent;
      do @(negedge clock); while (points_sent == seen);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_BITS-1:0] idx, logic [15:0] value);
      repeat (3) @(negedge clock);
      while (!req_ready) @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      apply_register(idx, value);
   endtask

   function automatic logic signed [11:0] pick_coord();
      if ($urandom_range(99) < 80) return $urandom_range(400) - 200;
      return $urandom;
   endfunction

   task automatic send_pass(int measures, int transforms);
      send_point(OP_MEASURE, 1'b1, pick_coord(), pick_coord(), pick_coord(), $urandom);
      repeat (measures)
         send_point(OP_MEASURE, 1'b0, pick_coord(), pick_coord(), pick_coord(), $urandom);
      repeat (transforms)
         send_point(OP_TRANSFORM, $urandom_range(1), pick_coord(), pick_coord(),
                    pick_coord(), $urandom);
   endtask

   task automatic send_mixed_traffic(int count);
      int n;
      n = 0;
      while (n < count) begin
         if ($urandom_range(99) < 85) begin
            int m, t;
            m = $urandom_range(6);
            t = $urandom_range(10, 1);
            send_pass(m, t);
            n += 1 + m + t;
         end else begin
            send_point($urandom_range(1), $urandom_range(1), $urandom, $urandom, $urandom,
                       $urandom);
            n++;
         end
      end
   endtask

   task automatic test_reset_settings();
      send_point(OP_TRANSFORM, 1'b0, 12'sd0, 12'sd0, 12'sd0, 32'h0000_0000);
      send_point(OP_TRANSFORM, 1'b0, 12'sd2047, 12'sd2047, 12'sd2047, 32'hFFFF_FFFF);
      send_point(OP_TRANSFORM, 1'b0, -12'sd2048, -12'sd2048, -12'sd2048, 32'h5555_AAAA);
      send_point(OP_MEASURE, 1'b1, 12'sd5, -12'sd3, 12'sd1, 32'h0);
      send_point(OP_TRANSFORM, 1'b1, 12'sd5, -12'sd3, 12'sd1, 32'h1234_5678);
      send_point(OP_MEASURE, 1'b0, 12'sd2047, -12'sd2048, 12'sd0, 32'h0);
      send_point(OP_MEASURE, 1'b0, 12'sd1, 12'sd1, 12'sd1, 32'h0);
      send_point(OP_TRANSFORM, 1'b0, 12'sd100, 12'sd50, -12'sd20, 32'hAAAA_5555);
      settle();
   endtask

   task automatic test_special_cases();
      write_register(CSR_SCALE, 16'd1023);
      write_register(CSR_MONO, 16'd1);
      write_register(CSR_UNUSED, 16'hFFFF);
      send_point(OP_MEASURE, 1'b1, 12'sd2047, 12'sd2047, -12'sd2048, 32'h0);
      send_point(OP_MEASURE, 1'b0, 12'sd0, 12'sd0, 12'sd0, 32'h0);
      send_point(OP_TRANSFORM, 1'b0, 12'sd2047, -12'sd2048, 12'sd2047, 32'h0F0F_F0F0);
      send_point(OP_MEASURE, 1'b1, 12'sd1, 12'sd1, 12'sd1, 32'h0);
      send_point(OP_TRANSFORM, 1'b0, -12'sd2048, 12'sd2047, -12'sd2048, 32'hF0F0_0F0F);
      settle();
      write_register(CSR_SCALE, 16'd0);
      write_register(CSR_MONO, 16'd0);
      send_point(OP_MEASURE, 1'b1, 12'sd300, 12'sd300, 12'sd300, 32'h0);
      send_point(OP_TRANSFORM, 1'b0, 12'sd2047, 12'sd2047, 12'sd2047, 32'h8000_0001);
      settle();
      write_register(CSR_SCALE, 16'd60);
      settings_used += 2;
   endtask

   task automatic test_register_sweep();
      logic [15:0] angles [6];
      logic [15:0] scales [4];
      logic [15:0] offsets [4];
      angles = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'h2000};
      scales = '{16'd1, 16'd1023, 16'd200, 16'd3};
      offsets = '{16'h1000, 16'h0FFF, 16'h0000, 16'h1FFF};
      for (int i = 0; i < 6; i++) begin
         write_register(CSR_ANGLE_X, angles[i]);
         write_register(CSR_ANGLE_Y, angles[(i + 2) % 6]);
         write_register(CSR_ANGLE_Z, angles[(i + 4) % 6]);
         write_register(CSR_SCALE, scales[i % 4]);
         write_register(CSR_OFFSET_X, offsets[i % 4]);
         write_register(CSR_OFFSET_Y, offsets[(i + 1) % 4]);
         write_register(CSR_MONO, i[0]);
         send_mixed_traffic(30);
         settle();
         settings_used++;
      end
   endtask

   task automatic test_random_traffic(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      write_register(CSR_ANGLE_X, $urandom);
      write_register(CSR_ANGLE_Y, $urandom);
      write_register(CSR_ANGLE_Z, $urandom);
      write_register(CSR_SCALE, $urandom_range(1023, 1));
      write_register(CSR_OFFSET_X, $urandom_range(1400, 500));
      write_register(CSR_OFFSET_Y, $urandom_range(800, 300));
      write_register(CSR_MONO, $urandom_range(1));
      send_mixed_traffic(count);
      settle();
      settings_used++;
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      ang_x = ANGLE_X_RESET;
      ang_y = ANGLE_Y_RESET;
      ang_z = ANGLE_Z_RESET;
      init_scale = SCALE_RESET;
      fit_scale = SCALE_RESET;
      off_x = OFFSET_X_RESET;
      off_y = OFFSET_Y_RESET;
      mono = 1'b0;
      fit_halted = 1'b0;
      rebuild_rotation();
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_reset_settings();
      test_special_cases();
      test_register_sweep();
      test_random_traffic(0, 0, 250);
      test_random_traffic(73, 0, 250);
      test_random_traffic(0, 73, 250);
      test_random_traffic(27, 27, 250);
      $display("Sent %0d points and checked %0d vertex words under %0d register settings.",
               points_sent, words_checked, settings_used + 1);
      $display("Mismatches: %0d, words still expected: %0d", mismatches,
               expected_words.size());
      if (mismatches == 0 && expected_words.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
